[hdl/pli_pkg.sv]
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;
   localparam int TIME_W  = 48;
   localparam int VALUE_W = 32;
   localparam int SLOPE_W = 48;
   localparam int CNT_W   = 11;
   localparam int IDX_W   = 10;
   // Magnitude widths: |dt| < 2^49, |dy| < 2^33, |dq| < 2^49.
   localparam int DT_W    = 49;
   localparam int DY_W    = 33;
   localparam int PROD_W  = 82;
   localparam int QUO_W   = 53;   // quotient capped at 2^52

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SREAD  = 9'b000000010,
      ST_SCMP   = 9'b000000100,
      ST_RD0    = 9'b000001000,
      ST_RD1    = 9'b000010000,
      ST_MUL    = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_FIN    = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;
endpackage

[hdl/pli_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module pli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hdl/piecewise_linear_interpolator_unit.sv]
// Timing: a write beat lands in the table at its accept edge. A query runs in order through
// the binary search, the endpoint reads, the serial multiply, the slope and value divides,
// the finish step and the output register, which can stall on rsp_ready. A zero-length
// segment skips the arithmetic. One beat at a time: a write leaves the unit idle and ready,
// while a query holds req_ready low until it has been handed to the output register.
// Reset: synchronous, active high; clears the controller and sets num_points to 2.
module piecewise_linear_interpolator_unit
   import pli_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [CNT_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [IDX_W-1:0]    req_entry_index,
   input  logic [TIME_W-1:0]   req_entry_time,
   input  logic [VALUE_W-1:0]  req_entry_value,
   input  logic [TIME_W-1:0]   req_query_time,
   input  logic                req_last_query,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_interp_value,
   output logic [SLOPE_W-1:0]  rsp_slope,
   output logic [IDX_W-1:0]    rsp_segment_index,
   output logic                rsp_out_of_range,
   output logic                rsp_zero_interval,
   output logic                rsp_last
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = AW + 1;          // position counters reach TABLE_DEPTH
   localparam int RW = DT_W + 1;        // divider remainder

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  npts_ff;
   logic [PW-1:0]     nuse;             // clamped count
   logic [PW-1:0]     left_ff, left_in, right_ff, right_in;
   logic [PW-1:0]     mid;
   logic [PW-1:0]     seg_ff, seg_in;
   logic [AW-1:0]     rd_addr;
   logic [TIME_W-1:0] rd_time;
   logic [VALUE_W-1:0] rd_value;
   logic              wr_en;
   logic              wr_in_range;

   // query context
   logic signed [TIME_W-1:0]  qt_ff, qt_in;
   logic                      last_ff, last_in;
   logic signed [TIME_W-1:0]  tfirst_ff, tfirst_in, t0_ff, t0_in;
   logic signed [VALUE_W-1:0] y0_ff, y0_in;
   logic [1:0]                sub_ff, sub_in;  // sub-step of endpoint reads

   // arithmetic
   logic [DT_W-1:0]   adt_ff, adt_in;
   logic [DY_W-1:0]   ady_ff, ady_in;
   logic [DT_W-1:0]   adq_ff, adq_in;
   logic              neg_s_ff, neg_s_in, neg_v_ff, neg_v_in, zero_ff, zero_in;
   logic              oor_ff, oor_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              pass_ff, pass_in;      // 0 slope divide, 1 value divide
   logic [PROD_W-1:0] dvd_ff, dvd_in;        // dividend shifting out MSB first
   logic [RW-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              capd_ff, capd_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;

   // output register
   logic              ov_ff, ov_in;
   logic [VALUE_W-1:0] o_val_ff, o_val_in;
   logic [SLOPE_W-1:0] o_slp_ff, o_slp_in;
   logic [IDX_W-1:0]  o_seg_ff, o_seg_in;
   logic              o_oor_ff, o_oor_in, o_zero_ff, o_zero_in, o_last_ff, o_last_in;

   // table memories
   assign wr_in_range = ({1'b0, req_entry_index} < (IDX_W+1)'(TABLE_DEPTH));
   assign wr_en = req_valid && req_ready && (req_command == CMD_WRITE) && wr_in_range;

   pli_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_DEPTH)) u_times (
      .clock(clock), .wr_en(wr_en), .wr_addr(AW'(req_entry_index)),
      .wr_data(req_entry_time), .rd_addr(rd_addr), .rd_data(rd_time));
   pli_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_values (
      .clock(clock), .wr_en(wr_en), .wr_addr(AW'(req_entry_index)),
      .wr_data(req_entry_value), .rd_addr(rd_addr), .rd_data(rd_value));

   // clamp count to [2, TABLE_DEPTH]
   always_comb begin
      if (npts_ff < CNT_W'(2)) begin
         nuse = PW'(2);
      end else if (32'(npts_ff) > TABLE_DEPTH) begin
         nuse = PW'(TABLE_DEPTH);
      end else begin
         nuse = PW'(npts_ff);
      end
   end

   assign mid = left_ff + ((right_ff - left_ff) >> 1);

   // divider step on the current dividend MSB
   logic [RW-1:0] rem_sh;
   logic          ge;
   assign rem_sh = {rem_ff[RW-2:0], dvd_ff[PROD_W-1]};
   assign ge     = rem_sh >= {1'b0, adt_ff};

   // result composition
   logic signed [QUO_W:0]     sq;
   logic signed [QUO_W+1:0]   ysum;
   logic signed [VALUE_W-1:0] ysat;
   logic signed [SLOPE_W-1:0] ssat;
   localparam logic signed [QUO_W:0] SMAX = (QUO_W+1)'((64'sd1 <<< (SLOPE_W-1)) - 1);
   localparam logic signed [QUO_W+1:0] YMAX = (QUO_W+2)'((64'sd1 <<< (VALUE_W-1)) - 1);

   always_comb begin
      sq = neg_s_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (sq > SMAX) ssat = SLOPE_W'(SMAX);
      else if (sq < -SMAX - 1) ssat = SLOPE_W'(-SMAX - 1);
      else ssat = SLOPE_W'(sq);
      ysum = (QUO_W+2)'(y0_ff) +
             (neg_v_ff ? -$signed({2'b0, quo_ff}) : $signed({2'b0, quo_ff}));
      if (ysum > YMAX) ysat = VALUE_W'(YMAX);
      else if (ysum < -YMAX - 1) ysat = VALUE_W'(-YMAX - 1);
      else ysat = VALUE_W'(ysum);
   end

   logic signed [TIME_W:0] dt_w, dq_w;
   logic signed [VALUE_W:0] dy_w;

   always_comb begin
      state_in = state_ff;
      left_in = left_ff; right_in = right_ff; seg_in = seg_ff;
      qt_in = qt_ff; last_in = last_ff; tfirst_in = tfirst_ff; t0_in = t0_ff;
      y0_in = y0_ff; sub_in = sub_ff;
      adt_in = adt_ff; ady_in = ady_ff; adq_in = adq_ff;
      neg_s_in = neg_s_ff; neg_v_in = neg_v_ff; zero_in = zero_ff; oor_in = oor_ff;
      prod_in = prod_ff; cnt_in = cnt_ff; pass_in = pass_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; quo_in = quo_ff; capd_in = capd_ff;
      slope_in = slope_ff;
      ov_in = ov_ff; o_val_in = o_val_ff; o_slp_in = o_slp_ff; o_seg_in = o_seg_ff;
      o_oor_in = o_oor_ff; o_zero_in = o_zero_ff; o_last_in = o_last_ff;
      rd_addr = AW'(mid);
      req_ready = 1'b0;
      dt_w = '0; dq_w = '0; dy_w = '0;

      if (ov_ff && rsp_ready) ov_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_command == CMD_QUERY) begin
               qt_in = req_query_time;
               last_in = req_last_query;
               left_in = '0;
               right_in = nuse;
               state_in = ST_SREAD;
            end
         end
         ST_SREAD: begin
            rd_addr = AW'(mid);
            if (left_ff < right_ff) begin
               state_in = ST_SCMP;
            end else begin
               // lower bound found; pick left breakpoint
               if (left_ff == '0) seg_in = '0;
               else seg_in = left_ff - PW'(1);
               if ((left_ff == '0 ? PW'(0) : left_ff - PW'(1)) > nuse - PW'(2))
                  seg_in = nuse - PW'(2);
               sub_in = 2'd0;
               state_in = ST_RD0;
            end
         end
         ST_SCMP: begin
            rd_addr = AW'(mid);
            if ($signed(rd_time) < qt_ff) left_in = mid + PW'(1);
            else right_in = mid;
            state_in = ST_SREAD;
         end
         ST_RD0: begin
            // sub 0: addr t[0]; 1: capture t[0], addr t[n-1];
            // 2: check last, addr seg; 3: capture seg, addr seg+1
            unique case (sub_ff)
               2'd0: begin
                  rd_addr = '0;
                  sub_in = 2'd1;
               end
               2'd1: begin
                  rd_addr = AW'(nuse - PW'(1));
                  tfirst_in = $signed(rd_time);
                  sub_in = 2'd2;
               end
               2'd2: begin
                  rd_addr = AW'(seg_ff);
                  oor_in = (qt_ff < tfirst_ff) || (qt_ff > $signed(rd_time));
                  sub_in = 2'd3;
               end
               default: begin
                  rd_addr = AW'(seg_ff + PW'(1));
                  t0_in = $signed(rd_time);
                  y0_in = $signed(rd_value);
                  state_in = ST_RD1;
               end
            endcase
         end
         ST_RD1: begin
            dt_w = $signed({rd_time[TIME_W-1], rd_time}) - $signed({t0_ff[TIME_W-1], t0_ff});
            dq_w = $signed({qt_ff[TIME_W-1], qt_ff}) - $signed({t0_ff[TIME_W-1], t0_ff});
            dy_w = $signed({rd_value[VALUE_W-1], rd_value}) -
                   $signed({y0_ff[VALUE_W-1], y0_ff});
            adt_in = dt_w[TIME_W] ? DT_W'(-dt_w) : DT_W'(dt_w);
            ady_in = dy_w[VALUE_W] ? DY_W'(-dy_w) : DY_W'(dy_w);
            adq_in = dq_w[TIME_W] ? DT_W'(-dq_w) : DT_W'(dq_w);
            zero_in = (dt_w == '0);
            neg_s_in = dy_w[VALUE_W] != dt_w[TIME_W];
            neg_v_in = (dy_w[VALUE_W] != dt_w[TIME_W]) != dq_w[TIME_W];
            prod_in = '0;
            cnt_in = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // shift-add: one multiplier bit of |dq| per cycle, MSB first
            if (zero_ff) begin
               state_in = ST_FIN;
            end else begin
               prod_in = {prod_ff[PROD_W-2:0], 1'b0} +
                         (adq_ff[DT_W-1] ? PROD_W'(ady_ff) : PROD_W'(0));
               adq_in = {adq_ff[DT_W-2:0], 1'b0};
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'(DT_W-1)) begin
                  // start slope divide: dividend |dy|<<32, top bits zero
                  cnt_in = 7'(PROD_W - DY_W - 32);    // skip the leading zeros
                  dvd_in = PROD_W'({ady_ff, 32'b0}) << (PROD_W - DY_W - 32);
                  rem_in = '0; quo_in = '0; capd_in = 1'b0;
                  pass_in = 1'b0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = ge ? rem_sh - {1'b0, adt_ff} : rem_sh;
            quo_in = {quo_ff[QUO_W-2:0], ge};
            dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if ({quo_ff[QUO_W-2:0], ge} >= {1'b1, {(QUO_W-1){1'b0}}} ||
                quo_ff[QUO_W-1]) begin
               capd_in = 1'b1;
               quo_in = {1'b1, {(QUO_W-1){1'b0}}};
            end
            if (capd_ff) begin
               quo_in = quo_ff;
               rem_in = rem_ff;
            end
            if (cnt_ff == 7'(PROD_W-1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (zero_ff) begin
               slope_in = '0;
               state_in = ST_OUT;
            end else if (!pass_ff) begin
               slope_in = ssat;
               dvd_in = prod_ff;
               rem_in = '0; quo_in = '0; capd_in = 1'b0;
               cnt_in = '0;
               pass_in = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // quotient and slope stay put here until the output register frees
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               o_val_in = zero_ff ? y0_ff : ysat;
               o_slp_in = slope_ff;
               o_seg_in = IDX_W'(seg_ff);
               o_oor_in = oor_ff;
               o_zero_in = zero_ff;
               o_last_in = last_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         npts_ff  <= CNT_W'(2);
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         if (csr_write_enable) npts_ff <= csr_write_data;
      end
      left_ff <= left_in; right_ff <= right_in; seg_ff <= seg_in;
      qt_ff <= qt_in; last_ff <= last_in; tfirst_ff <= tfirst_in; t0_ff <= t0_in;
      y0_ff <= y0_in; sub_ff <= sub_in;
      adt_ff <= adt_in; ady_ff <= ady_in; adq_ff <= adq_in;
      neg_s_ff <= neg_s_in; neg_v_ff <= neg_v_in; zero_ff <= zero_in; oor_ff <= oor_in;
      prod_ff <= prod_in; cnt_ff <= cnt_in; pass_ff <= pass_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; quo_ff <= quo_in; capd_ff <= capd_in;
      slope_ff <= slope_in;
      o_val_ff <= o_val_in; o_slp_ff <= o_slp_in; o_seg_ff <= o_seg_in;
      o_oor_ff <= o_oor_in; o_zero_ff <= o_zero_in; o_last_ff <= o_last_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_interp_value  = o_val_ff;
   assign rsp_slope         = o_slp_ff;
   assign rsp_segment_index = o_seg_ff;
   assign rsp_out_of_range  = o_oor_ff;
   assign rsp_zero_interval = o_zero_ff;
   assign rsp_last          = o_last_ff;

`ifndef ASSERT_OFF
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCMP) |-> (left_ff < right_ff))
      else $error("search bounds crossed");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("ready outside idle");
   a_zero_slope: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_interval) |-> (rsp_slope == '0))
      else $error("zero interval with nonzero slope");
   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD1) |-> (seg_ff <= nuse - PW'(2)))
      else $error("segment beyond table");
`endif
endmodule
